// File: rtl/vsd_pkg.sv
// Shared constants, codes and types of the voxel speck detector.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none
package vsd_pkg;

    // Defaults of the top-level parameters.
    localparam int MAX_SIDE_DEF   = 512;
    localparam int TYPE_BITS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 40;

    // Fixed widths of the channel fields.
    localparam int REQ_W      = 2;
    localparam int VOX_W      = 8;
    localparam int POS_W      = 42;
    localparam int CNT_W      = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 42;
    localparam int SIZE_XY_W  = 10;
    localparam int SIZE_Z_W   = 11;
    localparam int CLAMP_W    = 12;

    // Depth of the result queue.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_VOXEL = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Result kinds.
    localparam logic KIND_SPECK = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR      = 3'd6;

    // Register reset values.
    localparam logic [SIZE_XY_W-1:0] SIZE_X_RST = 10'd258;
    localparam logic [SIZE_XY_W-1:0] SIZE_Y_RST = 10'd258;
    localparam logic [SIZE_Z_W-1:0]  SIZE_Z_RST = 11'd66;
    localparam int                   SIDE_MIN   = 3;

    // Number of neighbours of a voxel.
    localparam int NB_CNT = 6;

    // Verdict of the stencil for the voxel under judgement.
    typedef struct packed {
        logic surf;
        logic speck;
    } t_jctl;

    // Update of the tally store for the item in its last stage.
    typedef struct packed {
        logic bump_surf;
        logic bump_speck;
        logic clear;
    } t_tally_op;

    // One result beat.
    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] speck_x;
        logic [POS_W-1:0] speck_y;
        logic [POS_W-1:0] speck_z;
        logic [VOX_W-1:0] was_type;
        logic [VOX_W-1:0] becomes_type;
        logic [CNT_W-1:0] surface_count;
        logic [CNT_W-1:0] speck_count;
    } t_res;

endpackage
`default_nettype wire

// File: rtl/vsd_req_if.sv
// Request channel of the voxel speck detector: valid, ready and one request beat.
// Depends on vsd_pkg for the field widths.
`default_nettype none
interface vsd_req_if;
    logic                       valid;
    logic                       ready;
    logic [vsd_pkg::REQ_W-1:0]  req_type;
    logic [vsd_pkg::VOX_W-1:0]  voxel_type;
    logic [vsd_pkg::VOX_W-1:0]  type_index;

    modport source (output valid, req_type, voxel_type, type_index, input ready);
    modport sink   (input valid, req_type, voxel_type, type_index, output ready);
endinterface
`default_nettype wire

// File: rtl/vsd_res_if.sv
// Result channel of the voxel speck detector: valid, ready and one result beat.
// Depends on vsd_pkg for the field widths.
`default_nettype none
interface vsd_res_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [vsd_pkg::POS_W-1:0] speck_x;
    logic [vsd_pkg::POS_W-1:0] speck_y;
    logic [vsd_pkg::POS_W-1:0] speck_z;
    logic [vsd_pkg::VOX_W-1:0] was_type;
    logic [vsd_pkg::VOX_W-1:0] becomes_type;
    logic [vsd_pkg::CNT_W-1:0] surface_count;
    logic [vsd_pkg::CNT_W-1:0] speck_count;

    modport source (output valid, kind, speck_x, speck_y, speck_z, was_type, becomes_type,
                    surface_count, speck_count, input ready);
    modport sink   (input valid, kind, speck_x, speck_y, speck_z, was_type, becomes_type,
                    surface_count, speck_count, output ready);
endinterface
`default_nettype wire

// File: rtl/vsd_stencil.sv
// Raster position, plane memory, row memory and six-neighbour verdict of the detector.
// Depends on vsd_pkg.
`default_nettype none
module vsd_stencil #(
    parameter int MAX_SIDE  = vsd_pkg::MAX_SIDE_DEF,
    parameter int TYPE_BITS = vsd_pkg::TYPE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_restart,
    input  wire  [$clog2(MAX_SIDE):0]         i_sx,
    input  wire  [$clog2(MAX_SIDE):0]         i_sy,
    input  wire  [$clog2(2*MAX_SIDE):0]       i_sz,
    input  wire  [TYPE_BITS-1:0]              i_air,
    input  wire                               i_acc,
    input  wire  [TYPE_BITS-1:0]              i_voxel,
    output vsd_pkg::t_jctl                    o_ctl,
    output logic [TYPE_BITS-1:0]              o_mine,
    output logic [TYPE_BITS-1:0]              o_best,
    output logic [$clog2(MAX_SIDE)-1:0]       o_cx,
    output logic [$clog2(MAX_SIDE)-1:0]       o_cy,
    output logic [$clog2(2*MAX_SIDE)-1:0]     o_cz
);
    localparam int XB = $clog2(MAX_SIDE);
    localparam int ZB = $clog2(2*MAX_SIDE);
    localparam int TB = TYPE_BITS;
    localparam int NB = vsd_pkg::NB_CNT;

    // Plane word: {latest plane value, plane before it} per column.
    logic [2*TB-1:0] r_pmem [2**(2*XB)];
    // Row word: {p and b of the next row, p of this row} per x.
    logic [3*TB-1:0] r_lmem [2**XB];

    logic [XB-1:0] r_px, r_py;
    logic [ZB-1:0] r_pz;
    logic [XB-1:0] r_x, r_y;
    logic [ZB-1:0] r_z;
    logic [TB-1:0] r_v;
    logic          r_s1v;
    logic [2*TB-1:0] r_prd;
    logic [3*TB-1:0] r_lrd;
    logic [3*TB-1:0] r_dc;
    logic [TB-1:0]   r_dl_p;

    logic          x_last, y_last, z_last;
    logic [XB-1:0] p_ra_y, l_ra;
    logic [TB-1:0] nb [NB];
    logic [TB-1:0] mine;
    logic          interior, exposed, kin;
    logic [2:0]    cnt [NB];
    logic [2:0]    best_n;
    logic [TB-1:0] best;

    assign x_last = ({1'b0, r_px} == i_sx - 1'b1);
    assign y_last = ({1'b0, r_py} == i_sy - 1'b1);
    assign z_last = ({1'b0, r_pz} == i_sz - 1'b1);
    assign p_ra_y = y_last ? '0 : r_py + 1'b1;
    assign l_ra   = x_last ? '0 : r_px + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_px <= '0;
            r_py <= '0;
            r_pz <= '0;
        end else if (i_acc) begin
            r_px <= l_ra;
            if (x_last) begin
                r_py <= p_ra_y;
                if (y_last) begin
                    r_pz <= z_last ? '0 : r_pz + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else begin
            r_s1v <= i_acc;
        end
    end

    // Reads are issued on the accepting edge; the write-back happens in the cycle after.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_prd <= r_pmem[{p_ra_y, r_px}];
            r_lrd <= r_lmem[l_ra];
            r_x   <= r_px;
            r_y   <= r_py;
            r_z   <= r_pz;
            r_v   <= i_voxel;
        end
        if (r_s1v) begin
            r_pmem[{r_y, r_x}] <= {r_v, r_dc[3*TB-1:2*TB]};
            r_lmem[r_x]        <= {r_prd, r_dc[3*TB-1:2*TB]};
            r_dl_p             <= r_dc[3*TB-1:2*TB];
            r_dc               <= r_lrd;
        end
    end

    assign mine  = r_dc[3*TB-1:2*TB];
    assign nb[0] = r_dl_p;
    assign nb[1] = r_lrd[3*TB-1:2*TB];
    assign nb[2] = r_dc[TB-1:0];
    assign nb[3] = r_prd[2*TB-1:TB];
    assign nb[4] = r_dc[2*TB-1:TB];
    assign nb[5] = r_v;

    assign interior = (r_z >= ZB'(2)) && (r_x != '0) && ({1'b0, r_x} <= i_sx - 2'd2) &&
                      (r_y != '0) && ({1'b0, r_y} <= i_sy - 2'd2);

    always_comb begin
        exposed = 1'b0;
        kin     = 1'b0;
        for (int i = 0; i < NB; i++) begin
            if (nb[i] == i_air) begin
                exposed = 1'b1;
            end else if (nb[i] == mine) begin
                kin = 1'b1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            cnt[i] = '0;
            for (int j = 0; j < NB; j++) begin
                cnt[i] = cnt[i] + 3'(nb[j] == nb[i]);
            end
        end
    end

    // First strict maximum wins, so ties go to the earliest neighbour.
    always_comb begin
        best   = i_air;
        best_n = '0;
        for (int i = 0; i < NB; i++) begin
            if (nb[i] != i_air && cnt[i] > best_n) begin
                best_n = cnt[i];
                best   = nb[i];
            end
        end
    end

    always_comb begin
        o_ctl.surf  = r_s1v && interior && (mine != i_air) && exposed;
        o_ctl.speck = o_ctl.surf && !kin;
    end

    assign o_mine = mine;
    assign o_best = best;
    assign o_cx   = r_x;
    assign o_cy   = r_y;
    assign o_cz   = r_z - 1'b1;
endmodule
`default_nettype wire

// File: rtl/vsd_tally.sv
// Per-type surface and speck counters in one memory, with forwarding and valid bits.
// Depends on vsd_pkg.
`default_nettype none
module vsd_tally #(
    parameter int TYPE_BITS  = vsd_pkg::TYPE_BITS_DEF,
    parameter int COUNT_BITS = vsd_pkg::COUNT_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_rd,
    input  wire  [TYPE_BITS-1:0]       i_rd_addr,
    input  vsd_pkg::t_tally_op         i_op,
    output logic [COUNT_BITS-1:0]      o_surf,
    output logic [COUNT_BITS-1:0]      o_speck
);
    localparam int TB = TYPE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int NT = 2**TB;

    logic [2*CB-1:0] r_mem [NT];
    logic [2*CB-1:0] r_rdata;
    logic [TB-1:0]   r_addr;
    logic [NT-1:0]   r_valid;
    logic            r_fv;
    logic [TB-1:0]   r_fa;
    logic [2*CB-1:0] r_fd;
    logic [2*CB-1:0] base;
    logic [CB-1:0]   surf_n, speck_n;

    // A write in the previous cycle is not yet visible in the read data.
    always_comb begin
        if (r_fv && r_fa == r_addr) begin
            base = r_fd;
        end else if (r_valid[r_addr]) begin
            base = r_rdata;
        end else begin
            base = '0;
        end
    end

    assign o_surf  = base[2*CB-1:CB];
    assign o_speck = base[CB-1:0];
    assign surf_n  = (&o_surf) ? o_surf : o_surf + 1'b1;
    assign speck_n = (i_op.bump_speck && !(&o_speck)) ? o_speck + 1'b1 : o_speck;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rdata <= r_mem[i_rd_addr];
            r_addr  <= i_rd_addr;
        end
        if (i_op.bump_surf) begin
            r_mem[r_addr] <= {surf_n, speck_n};
        end
        r_fa <= r_addr;
        r_fd <= {surf_n, speck_n};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_op.clear) begin
            r_valid <= '0;
            r_fv    <= 1'b0;
        end else begin
            r_fv <= i_op.bump_surf;
            if (i_op.bump_surf) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/vsd_outq.sv
// Small result queue that parts the pipeline from the result receiver.
// Depends on vsd_pkg and vsd_res_if.
`default_nettype none
module vsd_outq (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    input  vsd_pkg::t_res              i_data,
    output logic [vsd_pkg::OUTQ_AW:0]  o_count,
    vsd_res_if.source                  o_res
);
    localparam int AW = vsd_pkg::OUTQ_AW;

    vsd_pkg::t_res r_q [vsd_pkg::OUTQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          pop;
    vsd_pkg::t_res head;

    assign pop     = o_res.valid && o_res.ready;
    assign o_count = r_cnt;
    assign head    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end

    assign o_res.valid         = (r_cnt != '0);
    assign o_res.kind          = head.kind;
    assign o_res.speck_x       = head.speck_x;
    assign o_res.speck_y       = head.speck_y;
    assign o_res.speck_z       = head.speck_z;
    assign o_res.was_type      = head.was_type;
    assign o_res.becomes_type  = head.becomes_type;
    assign o_res.surface_count = head.surface_count;
    assign o_res.speck_count   = head.speck_count;
endmodule
`default_nettype wire

// File: rtl/voxel_speck_detector.sv
// Top level of the voxel speck detector: configuration registers, pipeline control, and the
// stencil, tally and result queue. Depends on vsd_pkg, vsd_req_if, vsd_res_if and those three.
//
// Usage. Request beats arrive on i_req: a voxel sample (raster order, x fastest, the
// one-voxel skirt included), a counter read for one type, or a clear of all counters.
// Result beats leave on o_res: a speck report, or a counter read reply.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so only while
// the block is idle (unenforced); a write to a size register restarts the box at its first voxel.
// Throughput: one request beat per cycle while the result queue has room. The plane memory
// and the row memory are each read once and written once per voxel, and the counter memory
// is read and written at most once per beat, so nothing in the datapath iterates.
// Pipeline: the edge that takes a request beat loads stage one; the verdict and the counter
// read are taken on the edge that loads stage two, and the counter update and queue write on
// the edge that ends stage two, after which the result is offered on o_res.
// Stalls: a four-entry result queue stands behind the pipeline; ready drops only when
// the queue plus the beats in flight fill it, so a stalled receiver costs no beat.
// Reset: the registers return to their defaults, the position to the first voxel and all
// counters read as zero at once; plane and row memories are not cleared, since each
// entry is written in a box before the verdict uses it.
`default_nettype none
module voxel_speck_detector #(
    parameter int MAX_SIDE   = vsd_pkg::MAX_SIDE_DEF,
    parameter int TYPE_BITS  = vsd_pkg::TYPE_BITS_DEF,
    parameter int COUNT_BITS = vsd_pkg::COUNT_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    vsd_req_if.sink                          i_req,
    vsd_res_if.source                        o_res,
    input  wire                              i_cfg_we,
    input  wire  [vsd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire  [vsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int XB = $clog2(MAX_SIDE);
    localparam int ZB = $clog2(2*MAX_SIDE);
    localparam int TB = TYPE_BITS;
    localparam int CB = COUNT_BITS;
    localparam int CW = vsd_pkg::CLAMP_W;
    localparam int PW = vsd_pkg::POS_W;

    // Configuration registers.
    logic [vsd_pkg::SIZE_XY_W-1:0] r_size_x, r_size_y;
    logic [vsd_pkg::SIZE_Z_W-1:0]  r_size_z;
    logic [PW-1:0]                 r_org_x, r_org_y, r_org_z;
    logic [TB-1:0]                 r_air;
    logic                          restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= vsd_pkg::SIZE_X_RST;
            r_size_y <= vsd_pkg::SIZE_Y_RST;
            r_size_z <= vsd_pkg::SIZE_Z_RST;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_z  <= '0;
            r_air    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vsd_pkg::CFG_SIZE_X:   r_size_x <= i_cfg_data[vsd_pkg::SIZE_XY_W-1:0];
                vsd_pkg::CFG_SIZE_Y:   r_size_y <= i_cfg_data[vsd_pkg::SIZE_XY_W-1:0];
                vsd_pkg::CFG_SIZE_Z:   r_size_z <= i_cfg_data[vsd_pkg::SIZE_Z_W-1:0];
                vsd_pkg::CFG_ORIGIN_X: r_org_x  <= i_cfg_data[PW-1:0];
                vsd_pkg::CFG_ORIGIN_Y: r_org_y  <= i_cfg_data[PW-1:0];
                vsd_pkg::CFG_ORIGIN_Z: r_org_z  <= i_cfg_data[PW-1:0];
                vsd_pkg::CFG_AIR:      r_air    <= TB'(i_cfg_data[vsd_pkg::VOX_W-1:0]);
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == vsd_pkg::CFG_SIZE_X ||
                     i_cfg_idx == vsd_pkg::CFG_SIZE_Y || i_cfg_idx == vsd_pkg::CFG_SIZE_Z);

    // Sizes limited to the range the memories can hold.
    logic [CW-1:0]  ext_x, ext_y, ext_z;
    logic [CW-1:0]  lim_x, lim_y, lim_z;
    logic [XB:0]    sx, sy;
    logic [ZB:0]    sz;

    assign ext_x = CW'(r_size_x);
    assign ext_y = CW'(r_size_y);
    assign ext_z = CW'(r_size_z);
    assign lim_x = (ext_x < CW'(vsd_pkg::SIDE_MIN)) ? CW'(vsd_pkg::SIDE_MIN) :
                   (ext_x > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : ext_x;
    assign lim_y = (ext_y < CW'(vsd_pkg::SIDE_MIN)) ? CW'(vsd_pkg::SIDE_MIN) :
                   (ext_y > CW'(MAX_SIDE)) ? CW'(MAX_SIDE) : ext_y;
    assign lim_z = (ext_z < CW'(vsd_pkg::SIDE_MIN)) ? CW'(vsd_pkg::SIDE_MIN) :
                   (ext_z > CW'(2*MAX_SIDE)) ? CW'(2*MAX_SIDE) : ext_z;
    assign sx = lim_x[XB:0];
    assign sy = lim_y[XB:0];
    assign sz = lim_z[ZB:0];

    // Credit check against the result queue, counting the beats still in the pipeline.
    logic [vsd_pkg::OUTQ_AW:0] q_count;
    logic [vsd_pkg::OUTQ_AW+1:0] occupancy;
    logic in_fire, acc_voxel;
    logic r_s1v, r_s2v;

    assign occupancy   = (vsd_pkg::OUTQ_AW+2)'(q_count) + (vsd_pkg::OUTQ_AW+2)'(r_s1v) +
                         (vsd_pkg::OUTQ_AW+2)'(r_s2v);
    assign i_req.ready = (occupancy < (vsd_pkg::OUTQ_AW+2)'(vsd_pkg::OUTQ_DEPTH));
    assign in_fire     = i_req.valid && i_req.ready;
    assign acc_voxel   = in_fire && (i_req.req_type == vsd_pkg::REQ_VOXEL);

    // Stage one: memory data back, verdict formed.
    logic [vsd_pkg::REQ_W-1:0] r_s1_req;
    logic [TB-1:0]             r_s1_idx;
    vsd_pkg::t_jctl            jctl;
    logic [TB-1:0]             mine, best;
    logic [XB-1:0]             cx, cy;
    logic [ZB-1:0]             cz;

    vsd_stencil #(
        .MAX_SIDE  (MAX_SIDE),
        .TYPE_BITS (TYPE_BITS)
    ) u_stencil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_sx      (sx),
        .i_sy      (sy),
        .i_sz      (sz),
        .i_air     (r_air),
        .i_acc     (acc_voxel),
        .i_voxel   (TB'(i_req.voxel_type)),
        .o_ctl     (jctl),
        .o_mine    (mine),
        .o_best    (best),
        .o_cx      (cx),
        .o_cy      (cy),
        .o_cz      (cz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
        end else begin
            r_s1v <= in_fire;
            r_s2v <= r_s1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req <= i_req.req_type;
            r_s1_idx <= TB'(i_req.type_index);
        end
    end

    // Stage two: counter data back, counters updated, result queued.
    logic [vsd_pkg::REQ_W-1:0] r_s2_req;
    vsd_pkg::t_jctl            r_s2_ctl;
    logic [PW-1:0]             r_s2_x, r_s2_y, r_s2_z;
    logic [TB-1:0]             r_s2_was, r_s2_best;

    always_ff @(posedge i_clk) begin
        if (r_s1v) begin
            r_s2_req  <= r_s1_req;
            r_s2_ctl  <= jctl;
            r_s2_x    <= r_org_x + PW'(cx);
            r_s2_y    <= r_org_y + PW'(cy);
            r_s2_z    <= r_org_z + PW'(cz);
            r_s2_was  <= mine;
            r_s2_best <= best;
        end
    end

    logic               t_rd;
    logic [TB-1:0]      t_addr;
    vsd_pkg::t_tally_op t_op;
    logic [CB-1:0]      cnt_surf, cnt_speck;

    assign t_rd   = r_s1v && (r_s1_req == vsd_pkg::REQ_READ || r_s1_req == vsd_pkg::REQ_VOXEL);
    assign t_addr = (r_s1_req == vsd_pkg::REQ_READ) ? r_s1_idx : mine;

    always_comb begin
        t_op.bump_surf  = r_s2v && (r_s2_req == vsd_pkg::REQ_VOXEL) && r_s2_ctl.surf;
        t_op.bump_speck = r_s2v && (r_s2_req == vsd_pkg::REQ_VOXEL) && r_s2_ctl.speck;
        t_op.clear      = r_s2v && (r_s2_req == vsd_pkg::REQ_CLEAR);
    end

    vsd_tally #(
        .TYPE_BITS  (TYPE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (t_rd),
        .i_rd_addr (t_addr),
        .i_op      (t_op),
        .o_surf    (cnt_surf),
        .o_speck   (cnt_speck)
    );

    logic          push, is_read;
    vsd_pkg::t_res res;

    assign is_read = (r_s2_req == vsd_pkg::REQ_READ);
    assign push    = r_s2v && (is_read || t_op.bump_speck);

    // A read reply carries only the counters; a speck report carries none.
    always_comb begin
        res = '0;
        if (is_read) begin
            res.kind          = vsd_pkg::KIND_READ;
            res.surface_count = vsd_pkg::CNT_W'(cnt_surf);
            res.speck_count   = vsd_pkg::CNT_W'(cnt_speck);
        end else begin
            res.kind         = vsd_pkg::KIND_SPECK;
            res.speck_x      = r_s2_x;
            res.speck_y      = r_s2_y;
            res.speck_z      = r_s2_z;
            res.was_type     = vsd_pkg::VOX_W'(r_s2_was);
            res.becomes_type = vsd_pkg::VOX_W'(r_s2_best);
        end
    end

    vsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_count (q_count),
        .o_res   (o_res)
    );

    // The credit check must keep the queue from ever overflowing.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (q_count < (vsd_pkg::OUTQ_AW+1)'(vsd_pkg::OUTQ_DEPTH)) ||
                 (o_res.valid && o_res.ready))
        else $error("result queue overflow");

    // Every accepted beat moves through both stages without stalling.
    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1v ##1 r_s2v)
        else $error("beat lost inside the pipeline");

    // A speck verdict always comes with a surface count update.
    a_speck_surf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        jctl.speck |-> jctl.surf && $past(acc_voxel))
        else $error("speck verdict without a surface voxel");
endmodule
`default_nettype wire
